// ===== rtl/dual_interrupt_controller_unit_defines.svh =====
// Assertion macros used by the interrupt controller top-level RTL.
`ifndef DUAL_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH
`define DUAL_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DIC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dic assertion failed");

// Next-cycle implication, checked out of reset.
`define DIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dic assertion failed");

`endif

// ===== rtl/dic_pkg.sv =====
// Types, codes and helpers shared by the interrupt controller modules.
`default_nettype none
package dic_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  // OCW2 command field, bits 7..5
  localparam logic [2:0] OCW2_BASE_CLEAR = 3'b000;
  localparam logic [2:0] OCW2_EOI        = 3'b001;
  localparam logic [2:0] OCW2_NOP        = 3'b010;
  localparam logic [2:0] OCW2_SEOI       = 3'b011;
  localparam logic [2:0] OCW2_ROTATE     = 3'b100;
  localparam logic [2:0] OCW2_EOI_ROT    = 3'b101;
  localparam logic [2:0] OCW2_SET_BASE   = 3'b110;
  localparam logic [2:0] OCW2_SEOI_ROT   = 3'b111;

  // OCW3 read select, bits 1..0
  localparam logic [1:0] OCW3_READ_IRR = 2'b10;
  localparam logic [1:0] OCW3_READ_ISR = 2'b11;

  localparam logic [7:0] BYTE_NONE   = 8'hff;
  localparam logic [4:0] PORT_PREFIX = 5'b00001;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       port;      // 0 command port, 1 data port
    logic       line;
    logic       level;
    logic [2:0] line_idx;
    logic [7:0] data;
  } dic_chip_cmd_t;

  typedef struct packed {
    logic [7:0] irr;       // request bits after this word's line change
    logic [7:0] isr;
    logic [7:0] imr;
    logic [7:0] icw1;
    logic [7:0] icw2;
    logic       aeoi;
  } dic_chip_stat_t;

  typedef struct packed {
    logic        taken;
    logic        chip;
    logic [2:0]  lvl;
    logic [15:0] call;
  } dic_ack_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } dic_first_t;

  function automatic dic_first_t dic_first_set(input logic [7:0] v);
    dic_first_t r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = 3'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dic_chip.sv =====
// One 8259-style controller: registers, command decode, read port and ack update.
`default_nettype none
module dic_chip import dic_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire dic_chip_cmd_t  cmd,
  input  wire logic           ack,
  input  wire logic [2:0]     ack_lvl,
  output dic_chip_stat_t      stat,
  output logic [7:0]          rd_byte
);

  logic [7:0] imr, irr, isr, icw1, icw2, icw3, icw4, latched;
  logic [2:0] base;
  logic       exp2, exp3, exp4, latch_pend;

  logic [7:0] imr_next, irr_next, isr_next, icw1_next, icw2_next, icw3_next, icw4_next;
  logic [7:0] latched_next;
  logic [2:0] base_next;
  logic       exp2_next, exp3_next, exp4_next, latch_pend_next;

  logic [7:0]  irr_line;
  logic [15:0] isr_dbl;
  logic [7:0]  isr_rot;
  dic_first_t  rot_first;
  logic [2:0]  ns_lvl;
  logic [2:0]  cmd_lvl;

  always_comb begin
    irr_line = irr;
    if (cmd.line) begin
      irr_line[cmd.line_idx] = cmd.level;
    end
  end

  // Rotate so the priority base lands at bit 0 for the non-specific EOI search.
  assign isr_dbl   = {isr, isr} >> base;
  assign isr_rot   = isr_dbl[7:0];
  assign rot_first = dic_first_set(isr_rot);
  assign ns_lvl    = rot_first.idx + base;
  assign cmd_lvl   = cmd.data[2:0];

  assign stat.irr  = irr_line;
  assign stat.isr  = isr;
  assign stat.imr  = imr;
  assign stat.icw1 = icw1;
  assign stat.icw2 = icw2;
  assign stat.aeoi = icw4[1];

  always_comb begin
    rd_byte = '0;
    if (cmd.rd) begin
      if (cmd.port) begin
        rd_byte = imr;
      end else if (latch_pend) begin
        rd_byte = latched;
      end
    end
  end

  always_comb begin
    imr_next        = imr;
    irr_next        = irr;
    isr_next        = isr;
    icw1_next       = icw1;
    icw2_next       = icw2;
    icw3_next       = icw3;
    icw4_next       = icw4;
    latched_next    = latched;
    base_next       = base;
    exp2_next       = exp2;
    exp3_next       = exp3;
    exp4_next       = exp4;
    latch_pend_next = latch_pend;

    if (cmd.wr && !cmd.port) begin
      if (cmd.data[4]) begin
        icw1_next = cmd.data;
        exp2_next = 1'b1;
        exp3_next = ~cmd.data[1];
        exp4_next = cmd.data[0];
      end else if (cmd.data[3]) begin
        if (cmd.data[1:0] == OCW3_READ_IRR) begin
          latch_pend_next = 1'b1;
          latched_next    = irr;
        end else if (cmd.data[1:0] == OCW3_READ_ISR) begin
          latch_pend_next = 1'b1;
          latched_next    = isr & ~imr;
        end
      end else begin
        unique case (cmd.data[7:5])
          OCW2_BASE_CLEAR: base_next = '0;
          OCW2_EOI: begin
            if (rot_first.found) begin
              isr_next[ns_lvl] = 1'b0;
              irr_next[ns_lvl] = 1'b0;
            end
          end
          OCW2_NOP: ;
          OCW2_SEOI: begin
            if (isr[cmd_lvl]) begin
              isr_next[cmd_lvl] = 1'b0;
              irr_next[cmd_lvl] = 1'b0;
            end
          end
          OCW2_ROTATE: base_next = base + 3'd1;
          OCW2_EOI_ROT: begin
            if (rot_first.found) begin
              isr_next[ns_lvl] = 1'b0;
              irr_next[ns_lvl] = 1'b0;
              base_next        = base + 3'd1;
            end
          end
          OCW2_SET_BASE: base_next = cmd_lvl;
          OCW2_SEOI_ROT: begin
            if (isr[cmd_lvl]) begin
              isr_next[cmd_lvl] = 1'b0;
              irr_next[cmd_lvl] = 1'b0;
              base_next         = base + 3'd1;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd.wr && cmd.port) begin
      priority if (exp2) begin
        icw2_next = cmd.data;
        exp2_next = 1'b0;
      end else if (exp3) begin
        icw3_next = cmd.data;
        exp3_next = 1'b0;
      end else if (exp4) begin
        icw4_next = cmd.data;
        exp4_next = 1'b0;
      end else begin
        imr_next = cmd.data;
        isr_next = isr & cmd.data;
        irr_next = irr & cmd.data;
      end
    end

    // a command-port read hands out the latched byte once
    if (cmd.rd && !cmd.port) begin
      latch_pend_next = 1'b0;
    end

    if (cmd.line) begin
      irr_next = irr_line;
    end

    // the scan may pick this chip on a line change of the other chip
    if (ack) begin
      irr_next[ack_lvl] = 1'b0;
      isr_next[ack_lvl] = ~icw4[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imr        <= '1;
      irr        <= '0;
      isr        <= '0;
      icw1       <= '0;
      icw2       <= '0;
      icw3       <= '0;
      icw4       <= '0;
      latched    <= '0;
      base       <= '0;
      exp2       <= 1'b0;
      exp3       <= 1'b0;
      exp4       <= 1'b0;
      latch_pend <= 1'b0;
    end else if (en) begin
      imr        <= imr_next;
      irr        <= irr_next;
      isr        <= isr_next;
      icw1       <= icw1_next;
      icw2       <= icw2_next;
      icw3       <= icw3_next;
      icw4       <= icw4_next;
      latched    <= latched_next;
      base       <= base_next;
      exp2       <= exp2_next;
      exp3       <= exp3_next;
      exp4       <= exp4_next;
      latch_pend <= latch_pend_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dic_scan.sv =====
// Fixed-order acknowledge scan across the chips and call address build.
`default_nettype none
module dic_scan import dic_pkg::*; #(
  parameter int NUM_CHIPS = 2
) (
  input  wire dic_chip_stat_t stat [NUM_CHIPS],
  output dic_ack_t            ack
);

  always_comb begin
    logic       done;
    logic [7:0] hit;
    dic_first_t f;
    done = 1'b0;
    hit  = '0;
    f    = '0;
    ack  = '0;
    for (int c = 0; c < NUM_CHIPS; c++) begin
      if (!done) begin
        hit = stat[c].isr | (stat[c].irr & ~stat[c].imr);
        f   = dic_first_set(hit);
        if (f.found) begin
          done = 1'b1;
          // an in-service bit met first blocks everything after it
          if (!stat[c].isr[f.idx]) begin
            ack.taken = 1'b1;
            ack.chip  = 1'(c);
            ack.lvl   = f.idx;
            if (stat[c].icw1[2]) begin
              ack.call = {stat[c].icw2, stat[c].icw1[7:5], f.idx, 2'b00};
            end else begin
              ack.call = {stat[c].icw2, stat[c].icw1[7:6], f.idx, 3'b000};
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dual_interrupt_controller_unit.sv =====
// Cascaded pair of 8259-style interrupt controllers with a word-in, word-out interface.
`default_nettype none
`include "dual_interrupt_controller_unit_defines.svh"
// Each request word is a bus write, a bus read or a request line change; each gives
// exactly one response word. Throughput is one word per cycle while the response is
// taken without rsp_stall. A word sits in the input register while the decode,
// register update and priority scan settle, and then lands in the response register.
// The pipeline advances only while the response register is empty or being taken, so
// rsp_stall backs up into req_stall after one held word. Ports 0x08/0x09 address the
// first chip, 0x0c/0x0d the second; other addresses read 0xff and ignore writes.
module dual_interrupt_controller_unit import dic_pkg::*; #(
  parameter int NUM_CHIPS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  bus_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic [3:0]  line_number,
  input  wire logic        line_level,
  input  wire logic        cpu_ready,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [7:0]       read_data,
  output logic             int_taken,
  output logic [15:0]      call_address
);

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [7:0]  s1_addr;
  logic [7:0]  s1_data;
  logic [3:0]  s1_line;
  logic        s1_level;
  logic        s1_ready;

  logic        out_free, advance, accept;
  logic        port_match, do_scan, in_dev;
  logic [NUM_CHIPS-1:0] chip_addr_hit;

  dic_chip_cmd_t  chip_cmd  [NUM_CHIPS];
  dic_chip_stat_t chip_stat [NUM_CHIPS];
  logic [7:0]     chip_rd   [NUM_CHIPS];
  dic_ack_t       scan_ack;

  logic [7:0]  read_data_next;
  logic        int_taken_next;
  logic [15:0] call_address_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= operation;
      s1_addr  <= bus_addr;
      s1_data  <= write_data;
      s1_line  <= line_number;
      s1_level <= line_level;
      s1_ready <= cpu_ready;
    end
  end

  assign port_match = (s1_addr[7:3] == PORT_PREFIX) && !s1_addr[1];
  assign do_scan    = (s1_op == OP_LINE) && s1_ready;
  assign in_dev     = |chip_addr_hit;

  for (genvar c = 0; c < NUM_CHIPS; c++) begin : g_chip
    assign chip_addr_hit[c] = port_match && (s1_addr[2] == 1'(c));

    always_comb begin
      chip_cmd[c].wr       = (s1_op == OP_WRITE) && chip_addr_hit[c];
      chip_cmd[c].rd       = (s1_op == OP_READ) && chip_addr_hit[c];
      chip_cmd[c].port     = s1_addr[0];
      chip_cmd[c].line     = (s1_op == OP_LINE) && (s1_line[3] == 1'(c));
      chip_cmd[c].level    = s1_level;
      chip_cmd[c].line_idx = s1_line[2:0];
      chip_cmd[c].data     = s1_data;
    end

    dic_chip u_chip (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .cmd     (chip_cmd[c]),
      .ack     (do_scan && scan_ack.taken && (scan_ack.chip == 1'(c))),
      .ack_lvl (scan_ack.lvl),
      .stat    (chip_stat[c]),
      .rd_byte (chip_rd[c])
    );
  end

  dic_scan #(
    .NUM_CHIPS (NUM_CHIPS)
  ) u_scan (
    .stat (chip_stat),
    .ack  (scan_ack)
  );

  always_comb begin
    read_data_next    = '0;
    int_taken_next    = 1'b0;
    call_address_next = '0;
    if (s1_op == OP_READ) begin
      if (!in_dev) begin
        read_data_next = BYTE_NONE;
      end else begin
        for (int c = 0; c < NUM_CHIPS; c++) begin
          read_data_next = read_data_next | chip_rd[c];
        end
      end
    end
    if (do_scan && scan_ack.taken) begin
      int_taken_next    = 1'b1;
      call_address_next = scan_ack.call;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data    <= read_data_next;
      int_taken    <= int_taken_next;
      call_address <= call_address_next;
    end
  end

  `DIC_ASSERT_NOW(a_taken_no_read, clk, rst, rsp_valid && int_taken, read_data == 8'h00)
  `DIC_ASSERT_NOW(a_call_only_taken, clk, rst, rsp_valid && !int_taken, call_address == 16'h0000)
  `DIC_ASSERT_NOW(a_stall_needs_held, clk, rst, req_stall, s1_valid && rsp_valid)
  `DIC_ASSERT_NEXT(a_advance_fills, clk, rst, advance, rsp_valid)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the cascaded interrupt controller pair.
`timescale 1ns / 100ps
module tb;
  import dic_pkg::*;

  localparam int NUM_PICS = 2;
  localparam int STIM_WORDS = 1550;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [3:0] line;
    logic       lvl;
    logic       rdy;
    bit         drain;
  } pic_req_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic        taken;
    logic [15:0] call;
  } pic_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = '0;
  logic [7:0]  bus_addr = '0;
  logic [7:0]  write_data = '0;
  logic [3:0]  line_number = '0;
  logic        line_level = 1'b0;
  logic        cpu_ready = 1'b0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [7:0]  read_data;
  logic        int_taken;
  logic [15:0] call_address;

  dual_interrupt_controller_unit #(.NUM_CHIPS(NUM_PICS)) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .bus_addr     (bus_addr),
    .write_data   (write_data),
    .line_number  (line_number),
    .line_level   (line_level),
    .cpu_ready    (cpu_ready),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .read_data    (read_data),
    .int_taken    (int_taken),
    .call_address (call_address)
  );

  // Predicted controller state, one entry per chip
  logic [7:0] p_imr [NUM_PICS];
  logic [7:0] p_irr [NUM_PICS];
  logic [7:0] p_isr [NUM_PICS];
  logic [2:0] p_base [NUM_PICS];
  logic [7:0] p_icw1 [NUM_PICS];
  logic [7:0] p_icw2 [NUM_PICS];
  logic [7:0] p_icw3 [NUM_PICS];
  logic [7:0] p_icw4 [NUM_PICS];
  bit         p_want2 [NUM_PICS];
  bit         p_want3 [NUM_PICS];
  bit         p_want4 [NUM_PICS];
  bit         p_latch_on [NUM_PICS];
  logic [7:0] p_latch_val [NUM_PICS];

  pic_req_t pending [$];
  pic_rsp_t rsp_due [$];
  pic_req_t cur_req;
  int       stim_count = 0;
  int       accepted_count = 0;
  int       rsp_count = 0;
  int       mismatches = 0;
  int       burst_left = 1;
  int       gap_left = 0;
  int       hold_left = 0;
  int       next_hold_at = 400;
  int       pattern_left = 0;
  int       stall_mode = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("[dual_interrupt_controller_unit] ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    if (mismatches <= 200)
      $display("mismatch on %s at response %0d: got %h, want %h", what, rsp_count, got, want);
  endtask

  function automatic void pic_reset();
    for (int c = 0; c < NUM_PICS; c++) begin
      p_imr[c] = 8'hff;
      p_irr[c] = '0;
      p_isr[c] = '0;
      p_base[c] = '0;
      p_icw1[c] = '0;
      p_icw2[c] = '0;
      p_icw3[c] = '0;
      p_icw4[c] = '0;
      p_want2[c] = 1'b0;
      p_want3[c] = 1'b0;
      p_want4[c] = 1'b0;
      p_latch_on[c] = 1'b0;
      p_latch_val[c] = '0;
    end
  endfunction

  // Chip for a port address, or -1 outside the device; dp marks the data port
  function automatic int port_chip(input logic [7:0] a, output bit dp);
    dp = a[0];
    if (a[7:3] != PORT_PREFIX || a[1]) return -1;
    if (int'(a[2]) >= NUM_PICS) return -1;
    return int'(a[2]);
  endfunction

  function automatic logic [7:0] pic_port(input int c, input bit dp);
    return {PORT_PREFIX, 1'(c), 1'b0, dp};
  endfunction

  // Non-specific EOI: clear the first in-service level from the rotation base
  function automatic bit eoi_lowest(input int c);
    logic [2:0] b;
    for (int k = 0; k < 8; k++) begin
      b = p_base[c] + 3'(k);
      if (p_isr[c][b]) begin
        p_isr[c][b] = 1'b0;
        p_irr[c][b] = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit eoi_level(input int c, input logic [2:0] lv);
    if (!p_isr[c][lv]) return 1'b0;
    p_isr[c][lv] = 1'b0;
    p_irr[c][lv] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void pic_command(input int c, input logic [7:0] d);
    if (d[4]) begin
      p_icw1[c] = d;
      p_want2[c] = 1'b1;
      p_want3[c] = ~d[1];
      p_want4[c] = d[0];
    end else if (d[3]) begin
      if (d[1:0] == OCW3_READ_IRR) begin
        p_latch_on[c] = 1'b1;
        p_latch_val[c] = p_irr[c];
      end else if (d[1:0] == OCW3_READ_ISR) begin
        p_latch_on[c] = 1'b1;
        p_latch_val[c] = p_isr[c] & ~p_imr[c];
      end
    end else begin
      case (d[7:5])
        OCW2_BASE_CLEAR: p_base[c] = '0;
        OCW2_EOI:        void'(eoi_lowest(c));
        OCW2_SEOI:       void'(eoi_level(c, d[2:0]));
        OCW2_ROTATE:     p_base[c] = p_base[c] + 3'd1;
        OCW2_EOI_ROT:    if (eoi_lowest(c)) p_base[c] = p_base[c] + 3'd1;
        OCW2_SET_BASE:   p_base[c] = d[2:0];
        OCW2_SEOI_ROT:   if (eoi_level(c, d[2:0])) p_base[c] = p_base[c] + 3'd1;
        default: ;
      endcase
    end
  endfunction

  function automatic void pic_data(input int c, input logic [7:0] d);
    if (p_want2[c]) begin
      p_icw2[c] = d;
      p_want2[c] = 1'b0;
    end else if (p_want3[c]) begin
      p_icw3[c] = d;
      p_want3[c] = 1'b0;
    end else if (p_want4[c]) begin
      p_icw4[c] = d;
      p_want4[c] = 1'b0;
    end else begin
      p_imr[c] = d;
      p_isr[c] = p_isr[c] & d;
      p_irr[c] = p_irr[c] & d;
    end
  endfunction

  // Fixed-order scan over both chips; an in-service level blocks everything after it
  function automatic void pic_scan(output bit hit, output logic [15:0] addr);
    logic [7:0] lo;
    hit = 1'b0;
    addr = '0;
    for (int pc = 0; pc < NUM_PICS; pc++) begin
      for (int i = 0; i < 8; i++) begin
        if (p_isr[pc][i]) return;
        if (p_irr[pc][i] && !p_imr[pc][i]) begin
          p_irr[pc][i] = 1'b0;
          p_isr[pc][i] = 1'b1;
          if (p_icw1[pc][2]) lo = (p_icw1[pc] & 8'he0) | 8'(i << 2);
          else lo = (p_icw1[pc] & 8'hc0) | 8'(i << 3);
          addr = {p_icw2[pc], lo};
          if (p_icw4[pc][1]) p_isr[pc][i] = 1'b0;
          hit = 1'b1;
          return;
        end
      end
    end
  endfunction

  function automatic pic_rsp_t pic_apply(input pic_req_t w);
    pic_rsp_t r;
    int c;
    bit dp;
    bit hit;
    logic [15:0] a;
    r = '0;
    case (w.op)
      OP_WRITE: begin
        c = port_chip(w.addr, dp);
        if (c >= 0) begin
          if (dp) pic_data(c, w.wdata);
          else pic_command(c, w.wdata);
        end
      end
      OP_READ: begin
        c = port_chip(w.addr, dp);
        if (c < 0) begin
          r.rd = BYTE_NONE;
        end else if (dp) begin
          r.rd = p_imr[c];
        end else if (p_latch_on[c]) begin
          p_latch_on[c] = 1'b0;
          r.rd = p_latch_val[c];
        end
      end
      OP_LINE: begin
        c = int'(w.line[3]);
        if (c < NUM_PICS) p_irr[c][w.line[2:0]] = w.lvl;
        if (w.rdy) begin
          pic_scan(hit, a);
          r.taken = hit;
          r.call = a;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pic_req_t rand_req();
    pic_req_t r;
    r.op = 2'($urandom);
    r.addr = 8'($urandom);
    r.wdata = 8'($urandom);
    r.line = 4'($urandom);
    r.lvl = 1'($urandom);
    r.rdy = 1'($urandom);
    r.drain = 1'b0;
    return r;
  endfunction

  task automatic queue_write(input logic [7:0] a, input logic [7:0] d);
    pic_req_t r;
    r = rand_req();
    r.op = OP_WRITE;
    r.addr = a;
    r.wdata = d;
    pending.push_back(r);
    stim_count++;
  endtask

  task automatic queue_read(input logic [7:0] a);
    pic_req_t r;
    r = rand_req();
    r.op = OP_READ;
    r.addr = a;
    pending.push_back(r);
    stim_count++;
  endtask

  task automatic queue_line(input logic [3:0] n, input logic lv, input logic rdy);
    pic_req_t r;
    r = rand_req();
    r.op = OP_LINE;
    r.line = n;
    r.lvl = lv;
    r.rdy = rdy;
    pending.push_back(r);
    stim_count++;
  endtask

  // Sender: bursts of words with random gaps; hold the payload while stalled
  always @(posedge clk) begin : req_drive
    logic v;
    if (rst) begin
      pic_reset();
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_due.push_back(pic_apply(cur_req));
        accepted_count++;
      end
      if (!req_valid || !req_stall) begin
        v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 && !(pending[0].drain && rsp_due.size() > 0)) begin
          cur_req = pending.pop_front();
          operation <= cur_req.op;
          bus_addr <= cur_req.addr;
          write_data <= cur_req.wdata;
          line_number <= cur_req.line;
          line_level <= cur_req.lvl;
          cpu_ready <= cur_req.rdy;
          v = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 4) == 0) begin
              burst_left = $urandom_range(30, 80);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left = $urandom_range(1, 6);
            end
          end
        end
        req_valid <= v;
      end
    end
  end

  // Receiver stall: a long hold-off now and then, otherwise a changing pattern
  always @(posedge clk) begin : rsp_hold
    logic s;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      s = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (accepted_count >= next_hold_at) begin
        hold_left = 150;
        next_hold_at += 700;
        s = 1'b1;
      end else begin
        if (pattern_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (stall_mode)
          0: s = 1'b0;
          1: s = ($urandom_range(0, 3) == 0);
          2: s = ($urandom_range(0, 3) != 0);
          default: s = ~rsp_stall;
        endcase
      end
      rsp_stall <= s;
    end
  end

  always @(posedge clk) begin : rsp_check
    pic_rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        note_mismatch("unexpected response", {read_data, 8'h00}, '0);
      end else begin
        e = rsp_due.pop_front();
        if (read_data !== e.rd) note_mismatch("read_data", 16'(read_data), 16'(e.rd));
        if (int_taken !== e.taken) note_mismatch("int_taken", 16'(int_taken), 16'(e.taken));
        if (call_address !== e.call) note_mismatch("call_address", call_address, e.call);
      end
      rsp_count++;
    end
  end

  initial begin : run
    pic_req_t r;
    int c;
    int pick;
    logic [7:0] icw1;

    // Directed: bring both chips up, then walk the special cases
    queue_read(pic_port(0, 1));
    queue_write(pic_port(0, 0), 8'h11);
    queue_write(pic_port(0, 1), 8'h20);
    queue_write(pic_port(0, 1), 8'h04);
    queue_write(pic_port(0, 1), 8'h01);
    queue_write(pic_port(1, 0), 8'hf7);
    queue_write(pic_port(1, 1), 8'hff);
    queue_write(pic_port(1, 1), 8'h02);
    queue_write(pic_port(0, 1), 8'h00);
    queue_write(pic_port(1, 1), 8'h00);
    queue_line(4'd3, 1'b1, 1'b1);
    queue_line(4'd15, 1'b1, 1'b1);
    queue_write(pic_port(0, 0), {3'b000, 2'b01, 1'b0, OCW3_READ_ISR});
    queue_read(pic_port(0, 0));
    queue_read(pic_port(0, 0));
    queue_write(pic_port(0, 0), {OCW2_EOI, 5'd0});
    queue_line(4'd8, 1'b1, 1'b1);
    queue_line(4'd0, 1'b1, 1'b0);
    queue_write(pic_port(0, 0), {3'b000, 2'b01, 1'b0, OCW3_READ_IRR});
    queue_read(pic_port(0, 0));
    queue_line(4'd8, 1'b0, 1'b1);
    queue_write(pic_port(0, 0), {OCW2_SEOI_ROT, 2'b00, 3'd0});
    queue_write(pic_port(0, 0), {OCW2_SET_BASE, 2'b00, 3'd7});
    queue_read(8'hff);
    queue_write(8'h00, 8'hff);
    r = rand_req();
    r.op = OP_SPARE;
    pending.push_back(r);

    // Random: mostly well-formed controller traffic, some noise
    while (stim_count < STIM_WORDS) begin
      c = $urandom_range(0, NUM_PICS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        icw1 = 8'($urandom) | 8'h10;
        queue_write(pic_port(c, 0), icw1);
        queue_write(pic_port(c, 1), 8'($urandom));
        if (!icw1[1]) queue_write(pic_port(c, 1), 8'($urandom));
        if (icw1[0]) queue_write(pic_port(c, 1), 8'($urandom));
      end else if (pick < 20) begin
        queue_write(pic_port(c, 1), 8'($urandom) & 8'($urandom));
      end else if (pick < 58) begin
        queue_line(4'($urandom), $urandom_range(0, 9) < 7, $urandom_range(0, 4) != 0);
      end else if (pick < 74) begin
        queue_write(pic_port(c, 0), {3'($urandom), 2'b00, 3'($urandom)});
      end else if (pick < 84) begin
        queue_write(pic_port(c, 0), {3'($urandom), 2'b01, 3'($urandom)});
        if ($urandom_range(0, 3) != 0) queue_read(pic_port(c, 0));
      end else if (pick < 93) begin
        queue_read(pic_port(c, $urandom_range(0, 1)));
      end else begin
        r = rand_req();
        if ($urandom_range(0, 1) == 0) r.addr = {PORT_PREFIX, 3'($urandom)};
        pending.push_back(r);
      end
    end

    // Pause the sender until the block has drained, twice during the run
    pending[pending.size() * 2 / 5].drain = 1'b1;
    pending[pending.size() * 4 / 5].drain = 1'b1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || req_valid) @(posedge clk);
    while (rsp_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("[dual_interrupt_controller_unit] OK");
    else
      $display("[dual_interrupt_controller_unit] ERROR");
    $finish;
  end

endmodule
